[hw/rtl/wom_pkg.sv]
// Shared types and constants for the window overlap matrix update unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package wom_pkg;

  // Operation codes carried by a word on the input channel.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Field widths of the channels.
  localparam int OP_W    = 2;
  localparam int WIN_W   = 4;
  localparam int COORD_W = 8;
  localparam int RES_W   = 16;

  // Default table size.
  localparam int DEF_WINDOW_COUNT = 16;

  // One stored window rectangle.
  typedef struct packed {
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] height;
    logic [COORD_W-1:0] width;
  } rect_t;

  // Rectangle of a slot that was never loaded.
  localparam rect_t RECT_RESET = '{top: 8'd0, left: 8'd0, height: 8'd1, width: 8'd1};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // capture the input word and issue the target read
    logic fetch;     // latch the target record, perform a load
    logic scan;      // process one slot of the overlap scan
    logic finish;    // write back the target row
    logic load_out;  // load the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic upd_go;     // captured word is an update of an addressable window
    logic scan_last;  // scan is at the last slot
    logic out_busy;   // output register holds a word that is stalled
  } ctl_sts_t;

endpackage

`default_nettype wire

[hw/rtl/wom_ctrl.sv]
// Controller state machine of the window overlap matrix update unit.
// Depends on wom_pkg for the command and status structs.
`default_nettype none

module wom_ctrl
  import wom_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FETCH  = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = sts.upd_go ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A new word is taken only between items.
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted word always moves on to the fetch cycle.
  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_FETCH))
    else $error("accepted word did not enter the fetch cycle");

  // The scan leaves only after its last slot.
  a_scan_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !sts.scan_last) |=> (state_r == S_SCAN))
    else $error("scan ended before the last slot");

  // The output register is never overwritten while its word is stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.out_busy)
    else $error("output register loaded while stalled");

  // A scan is entered only for an update of an addressable window.
  a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH && !sts.upd_go) |=> (state_r == S_FINISH))
    else $error("scan started for a word that is not an update");

endmodule

`default_nettype wire

[hw/rtl/wom_datapath.sv]
// Datapath of the window overlap matrix update unit: slot records, overlap
// matrix memory, scan counter, intersection test and output register.
// Depends on wom_pkg for types, constants and the command and status structs.
`default_nettype none

module wom_datapath
  import wom_pkg::*;
#(
  parameter int WINDOW_COUNT = DEF_WINDOW_COUNT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctl_cmd_t           cmd,
  output ctl_sts_t                sts,
  input  wire logic [OP_W-1:0]    in_operation,
  input  wire logic [WIN_W-1:0]   in_window,
  input  wire logic               in_enable,
  input  wire logic               in_in_use,
  input  wire logic               in_overlapped,
  input  wire logic [COORD_W-1:0] in_top_row,
  input  wire logic [COORD_W-1:0] in_left_col,
  input  wire logic [COORD_W-1:0] in_height,
  input  wire logic [COORD_W-1:0] in_width,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic [RES_W-1:0]        out_overlap_row,
  output logic [RES_W-1:0]        out_overlapped_flags,
  output logic                    out_window_in_use
);

  localparam int IDXW = $clog2(WINDOW_COUNT);
  localparam int EXTW = (WINDOW_COUNT > RES_W) ? WINDOW_COUNT : RES_W;
  localparam int EDGE_W = COORD_W + 1;

  // Captured input word.
  logic [OP_W-1:0]    op_r;
  logic [WIN_W-1:0]   win_r;
  logic               en_r;
  logic               use_in_r;
  logic               ovl_in_r;
  rect_t              rect_in_r;

  // Slot flags, with valid bits for the rectangle and matrix memories.
  logic [WINDOW_COUNT-1:0] use_r;
  logic [WINDOW_COUNT-1:0] ovl_r;
  logic [WINDOW_COUNT-1:0] rect_vld_r;
  logic [WINDOW_COUNT-1:0] row_vld_r;

  // Memories.
  rect_t                   rect_mem [WINDOW_COUNT];
  logic [WINDOW_COUNT-1:0] row_mem  [WINDOW_COUNT];

  // Registered read port.
  rect_t                   rd_rect_r;
  logic                    rd_rvld_r;
  logic [WINDOW_COUNT-1:0] rd_row_r;
  logic                    rd_mvld_r;

  // Target record held over the scan.
  logic [WINDOW_COUNT-1:0] t_row_r;
  logic [COORD_W-1:0]      t_top_r;
  logic [COORD_W-1:0]      t_left_r;
  logic [EDGE_W-1:0]       t_bot_r;
  logic [EDGE_W-1:0]       t_rgt_r;
  logic                    t_empty_r;

  logic [IDXW-1:0] scan_cnt_r;

  logic             out_valid_r;
  logic [RES_W-1:0] out_row_r;
  logic [RES_W-1:0] out_flags_r;
  logic             out_use_r;

  logic                    win_ok;
  logic [IDXW-1:0]         t_idx;
  logic [IDXW-1:0]         rd_addr;
  rect_t                   rect_eff;
  logic [WINDOW_COUNT-1:0] row_eff;
  logic [EDGE_W-1:0]       eff_bot;
  logic [EDGE_W-1:0]       eff_rgt;
  logic                    eff_empty;
  logic                    meet;
  logic                    hit;
  logic [WINDOW_COUNT-1:0] t_bit;
  logic [WINDOW_COUNT-1:0] row_new;
  logic                    rect_we;
  logic                    row_we;
  logic [IDXW-1:0]         row_waddr;
  logic [WINDOW_COUNT-1:0] row_wdata;
  logic [EXTW-1:0]         use_ext;
  logic [EXTW-1:0]         ovl_ext;
  logic [EXTW-1:0]         row_ext;

  assign win_ok = (32'(win_r) < WINDOW_COUNT);
  assign t_idx  = IDXW'(win_r);

  // Status toward the controller.
  assign sts.upd_go    = (op_r == OP_UPDATE) && win_ok;
  assign sts.scan_last = (scan_cnt_r == IDXW'(WINDOW_COUNT - 1));
  assign sts.out_busy  = out_valid_r && out_stall;

  // Read address: the addressed window on accept, then one slot ahead of the scan.
  always_comb begin
    if (cmd.accept) begin
      rd_addr = IDXW'(in_window);
    end else if (cmd.scan && !sts.scan_last) begin
      rd_addr = scan_cnt_r + IDXW'(1);
    end else begin
      rd_addr = scan_cnt_r;
    end
  end

  // A slot never written reads as its reset value.
  assign rect_eff = rd_rvld_r ? rd_rect_r : RECT_RESET;
  assign row_eff  = rd_mvld_r ? rd_row_r : '0;

  // Inclusive edge intersection of the scanned slot with the target.
  assign eff_bot   = {1'b0, rect_eff.top} + {1'b0, rect_eff.height} - EDGE_W'(1);
  assign eff_rgt   = {1'b0, rect_eff.left} + {1'b0, rect_eff.width} - EDGE_W'(1);
  assign eff_empty = (rect_eff.height == '0) || (rect_eff.width == '0);
  assign meet = !t_empty_r && !eff_empty &&
                !(eff_bot < {1'b0, t_top_r}) && !(t_bot_r < {1'b0, rect_eff.top}) &&
                !(eff_rgt < {1'b0, t_left_r}) && !(t_rgt_r < {1'b0, rect_eff.left});

  assign hit = cmd.scan && use_r[scan_cnt_r] && (scan_cnt_r != t_idx) && meet;

  // Scanned row with the target's bit set or cleared.
  assign t_bit   = WINDOW_COUNT'(1) << t_idx;
  assign row_new = en_r ? (row_eff | t_bit) : (row_eff & ~t_bit);

  // Matrix write port: scanned row during the scan, target row at the end.
  assign rect_we   = cmd.fetch && (op_r == OP_LOAD) && win_ok;
  assign row_we    = hit || (cmd.finish && sts.upd_go);
  assign row_waddr = cmd.finish ? t_idx : scan_cnt_r;
  assign row_wdata = cmd.finish ? t_row_r : row_new;

  // Memory read and write.
  always_ff @(posedge clk) begin
    rd_rect_r <= rect_mem[rd_addr];
    rd_row_r  <= row_mem[rd_addr];
    rd_rvld_r <= rect_vld_r[rd_addr];
    rd_mvld_r <= row_vld_r[rd_addr];
    if (rect_we) begin
      rect_mem[t_idx] <= rect_in_r;
    end
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
  end

  // Input capture and target record.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_operation;
      win_r     <= in_window;
      en_r      <= in_enable;
      use_in_r  <= in_in_use;
      ovl_in_r  <= in_overlapped;
      rect_in_r <= '{top: in_top_row, left: in_left_col, height: in_height,
                     width: in_width};
    end
    if (cmd.fetch) begin
      t_row_r   <= row_eff;
      t_top_r   <= rect_eff.top;
      t_left_r  <= rect_eff.left;
      t_bot_r   <= eff_bot;
      t_rgt_r   <= eff_rgt;
      t_empty_r <= eff_empty;
    end else if (hit) begin
      t_row_r[scan_cnt_r] <= en_r;
    end
  end

  // Slot flags and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r      <= '0;
      ovl_r      <= '0;
      rect_vld_r <= '0;
      row_vld_r  <= '0;
    end else begin
      if (rect_we) begin
        use_r[t_idx]      <= use_in_r;
        ovl_r[t_idx]      <= ovl_in_r;
        rect_vld_r[t_idx] <= 1'b1;
      end
      // A cleared pair can leave the other window with no overlaps at all.
      if (hit && !en_r && ovl_r[scan_cnt_r] && (row_new == '0)) begin
        ovl_r[scan_cnt_r] <= 1'b0;
      end
      if (row_we) begin
        row_vld_r[row_waddr] <= 1'b1;
      end
    end
  end

  // Scan counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
    end else if (cmd.accept) begin
      scan_cnt_r <= '0;
    end else if (cmd.scan && !sts.scan_last) begin
      scan_cnt_r <= scan_cnt_r + IDXW'(1);
    end
  end

  // Result word.
  assign use_ext = EXTW'(use_r);
  assign ovl_ext = EXTW'(ovl_r);
  assign row_ext = EXTW'(t_row_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_row_r   <= win_ok ? row_ext[RES_W-1:0] : '0;
      out_flags_r <= ovl_ext[RES_W-1:0];
      out_use_r   <= win_ok && use_ext[win_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.load_out || (out_valid_r && out_stall);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_overlap_row      = out_row_r;
  assign out_overlapped_flags = out_flags_r;
  assign out_window_in_use    = out_use_r;

endmodule

`default_nettype wire

[hw/rtl/window_overlap_matrix_update_unit.sv]
// Window overlap matrix update unit: a table of window records and their
// symmetric overlap matrix. Depends on wom_pkg, wom_ctrl and wom_datapath.
//
// Each accepted word gives one result word. A load or read word passes through
// the fetch and finish states before the next word is accepted; an update also
// scans every slot, and the scan reads one slot's rectangle and
// matrix row per cycle through the single read port of the slot memories and
// writes the changed row back on the next cycle. The result is held in an
// output register, so a stalled result delays the block only when the next
// result is ready. The slot table needs no clearing pass after reset: a valid
// bit per slot makes a never-loaded slot read as its reset value.
`default_nettype none

module window_overlap_matrix_update_unit
  import wom_pkg::*;
#(
  parameter int WINDOW_COUNT = DEF_WINDOW_COUNT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [OP_W-1:0]    in_operation,
  input  wire logic [WIN_W-1:0]   in_window,
  input  wire logic               in_enable,
  input  wire logic               in_in_use,
  input  wire logic               in_overlapped,
  input  wire logic [COORD_W-1:0] in_top_row,
  input  wire logic [COORD_W-1:0] in_left_col,
  input  wire logic [COORD_W-1:0] in_height,
  input  wire logic [COORD_W-1:0] in_width,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [RES_W-1:0]        out_overlap_row,
  output logic [RES_W-1:0]        out_overlapped_flags,
  output logic                    out_window_in_use
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequencer.
  wom_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Slot storage and scan datapath.
  wom_datapath #(
    .WINDOW_COUNT (WINDOW_COUNT)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_operation         (in_operation),
    .in_window            (in_window),
    .in_enable            (in_enable),
    .in_in_use            (in_in_use),
    .in_overlapped        (in_overlapped),
    .in_top_row           (in_top_row),
    .in_left_col          (in_left_col),
    .in_height            (in_height),
    .in_width             (in_width),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_overlap_row      (out_overlap_row),
    .out_overlapped_flags (out_overlapped_flags),
    .out_window_in_use    (out_window_in_use)
  );

endmodule

`default_nettype wire
